/* sv/wosc_pkg.sv */
package wosc_pkg;

  // register indexes on the configuration port (byte address is 4 * index)
  localparam logic [1:0] REG_WAVEFORM = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  // waveform codes
  localparam logic [1:0] WAVE_SINE = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SAW = 2'd2;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

  // full scale in Q1.15
  localparam logic [15:0] UNITY = 16'd32768;

  // quarter sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FRAME = 8'b0000_0010,
    S_SQR   = 8'b0000_0100,
    S_CUBE  = 8'b0000_1000,
    S_QUAD  = 8'b0001_0000,
    S_LIN   = 8'b0010_0000,
    S_SHAPE = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

endpackage

/* sv/waveform_oscillator.sv */
// Waveform oscillator: a request with kind 1 restarts phase and frame position and
// produces no sample; a request with kind 0 asks for frame_count frames (clamped to
// MAX_BLOCK, zero gives nothing) and the block returns one sample per frame, with
// last on the final one. The polynomial products go through one shared 18x18
// multiplier under a small sequencer and the gain product has its own slot, so a
// sine frame runs four polynomial products, a shaping step and the gain product,
// square, sawtooth and triangle run only the gain product, and a frame past the
// configured length skips the arithmetic. The block is busy until it has handed its
// final sample to the output register, which then waits for out_ready while the
// next request is accepted. Configuration goes through the APB port at addresses
// 0, 4, 8, 12 (waveform, phase_step, amplitude, length_frames).
module waveform_oscillator
  import wosc_pkg::*;
#(
  parameter int MAX_BLOCK = 64,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [6:0]         frame_count,
  // sample channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               last,
  output logic               finished
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int R_W = SINE_ADDR_BITS - 2;
  localparam int R_SH = 16 - R_W;

  // configuration registers
  logic [1:0]  waveform;
  logic [31:0] phase_step;
  logic [15:0] amplitude;
  logic [31:0] length_frames;

  // oscillator state
  logic [31:0] phase_acc;
  logic [31:0] frame_position;

  // sequencer
  state_t state, state_next;
  logic [CNT_W-1:0] remain;
  logic             active;
  logic [16:0]      x;
  logic [16:0]      x2;
  logic             neg;
  logic signed [16:0] wave;
  logic signed [35:0] prod;

  logic signed [17:0] mul_a, mul_b;
  logic               mul_en;

  logic cfg_write;
  logic in_take;
  logic out_free;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign in_take = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= WAVE_SINE;
      phase_step <= '0;
      amplitude <= UNITY;
      length_frames <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_WAVEFORM:   waveform <= pwdata[1:0];
        REG_PHASE_STEP: phase_step <= pwdata;
        REG_AMPLITUDE:  amplitude <= pwdata[15:0];
        REG_LENGTH:     length_frames <= pwdata;
        default:        ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_WAVEFORM:   prdata = {30'd0, waveform};
      REG_PHASE_STEP: prdata = phase_step;
      REG_AMPLITUDE:  prdata = {16'd0, amplitude};
      REG_LENGTH:     prdata = length_frames;
      default:        prdata = '0;
    endcase
  end

  // request size, clamped
  logic [6:0] req_frames;
  assign req_frames = (frame_count > 7'(MAX_BLOCK)) ? 7'(MAX_BLOCK) : frame_count;

  // frame is live unless the configured length has been reached
  logic frame_live;
  assign frame_live = (length_frames == '0) || (frame_position < length_frames);

  // sine table address split into quadrant and position within the quarter
  logic [SINE_ADDR_BITS-1:0] sine_idx;
  logic [16:0]               x_raw;
  logic [16:0]               x_quarter;
  assign sine_idx = phase_acc[31 -: SINE_ADDR_BITS];
  assign x_raw = 17'(sine_idx[R_W-1:0]) << R_SH;
  assign x_quarter = sine_idx[SINE_ADDR_BITS-2] ? (17'h10000 - x_raw) : x_raw;

  // square, sawtooth and triangle straight from the phase
  logic [15:0]        tri_s;
  logic [16:0]        tri_mag;
  logic signed [17:0] tri_val;
  logic signed [16:0] plain_wave;
  assign tri_s = phase_acc[31:16] + 16'hC000;
  assign tri_mag = tri_s[15] ? {2'b00, tri_s[14:0]} : (17'h08000 - {1'b0, tri_s});
  assign tri_val = signed'({tri_mag, 1'b0}) - 18'sd32768;

  always_comb begin
    case (waveform)
      WAVE_SQUARE:   plain_wave = phase_acc[31] ? -17'sd32768 : 17'sd32768;
      WAVE_SAW:      plain_wave = {phase_acc[31], phase_acc[31:16]};
      WAVE_TRIANGLE: plain_wave = tri_val[16:0];
      default:       plain_wave = '0;
    endcase
  end

  // polynomial intermediate terms from the last product
  logic [15:0] poly_t;
  logic [16:0] poly_u;
  logic [17:0] y_inc;
  logic [16:0] sine_mag;
  assign poly_t = SIN_B - prod[31:16];
  assign poly_u = SIN_A - {1'b0, prod[31:16]};
  assign y_inc = {1'b0, prod[32:16]} + 18'd1;
  assign sine_mag = (y_inc[17:1] > {1'b0, UNITY}) ? {1'b0, UNITY} : y_inc[17:1];

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    case (state)
      S_SQR: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, x};
      end
      S_CUBE: begin
        mul_a = {1'b0, prod[32:16]};
        mul_b = {5'd0, SIN_C};
      end
      S_QUAD: begin
        mul_a = {1'b0, x2};
        mul_b = {2'd0, poly_t};
      end
      S_LIN: begin
        mul_a = {1'b0, x};
        mul_b = {1'b0, poly_u};
      end
      S_SHAPE: begin
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
      end
      S_FRAME: begin
        // gain product for non-sine waves is taken in the next state
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gain product uses its own slot in the sequence
  logic scale_now;
  logic signed [17:0] gain_a, gain_b;
  assign gain_a = {wave[16], wave};
  assign gain_b = {2'd0, amplitude};

  // round half up and saturate
  logic signed [35:0] rnd_sum;
  logic signed [20:0] rnd;
  logic signed [15:0] sat;
  assign rnd_sum = prod + 36'sd16384;
  assign rnd = rnd_sum[35:15];
  always_comb begin
    if (rnd > 21'sd32767) sat = 16'sh7FFF;
    else if (rnd < -21'sd32768) sat = 16'sh8000;
    else sat = rnd[15:0];
  end

  // position after this frame and the end-of-length flag
  logic [31:0] pos_adv;
  logic        fin_flag;
  assign pos_adv = active ? (frame_position + 32'd1) : frame_position;
  assign fin_flag = (length_frames != '0) && (pos_adv >= length_frames);

  // a scale pass marks itself by running S_SHAPE with the gain product pending
  logic gain_pending;

  // next state
  always_comb begin
    state_next = state;
    scale_now = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_take && !kind && req_frames != 7'd0) state_next = S_FRAME;
      end
      S_FRAME: begin
        if (!frame_live) state_next = S_EMIT;
        else if (waveform == WAVE_SINE) state_next = S_SQR;
        else state_next = S_SHAPE;
      end
      S_SQR:  state_next = S_CUBE;
      S_CUBE: state_next = S_QUAD;
      S_QUAD: state_next = S_LIN;
      S_LIN:  state_next = S_SHAPE;
      S_SHAPE: begin
        scale_now = gain_pending;
        state_next = gain_pending ? S_EMIT : S_SHAPE;
      end
      S_EMIT: begin
        if (out_free) state_next = (remain == CNT_W'(1)) ? S_IDLE : S_FRAME;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase_acc <= '0;
      frame_position <= '0;
      gain_pending <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_take && kind) begin
            phase_acc <= '0;
            frame_position <= '0;
          end
        end
        S_FRAME: begin
          gain_pending <= frame_live && (waveform != WAVE_SINE);
        end
        S_SHAPE: begin
          gain_pending <= !gain_pending;
        end
        S_EMIT: begin
          if (out_free && active) begin
            phase_acc <= phase_acc + phase_step;
            frame_position <= frame_position + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
    else if (scale_now) prod <= gain_a * gain_b;
    case (state)
      S_IDLE: begin
        if (in_take) remain <= CNT_W'(req_frames);
      end
      S_FRAME: begin
        active <= frame_live;
        x <= x_quarter;
        neg <= sine_idx[SINE_ADDR_BITS-1];
        wave <= plain_wave;
      end
      S_CUBE: x2 <= prod[32:16];
      S_SHAPE: begin
        if (!gain_pending) wave <= neg ? -signed'(sine_mag) : signed'(sine_mag);
      end
      S_EMIT: begin
        if (out_free) remain <= remain - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      sample <= active ? sat : 16'sd0;
      last <= (remain == CNT_W'(1));
      finished <= fin_flag;
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import wosc_pkg::*;

  localparam int BLOCK_MAX = 64;
  localparam int SETTLE_CYCLES = 24;
  localparam int IDLE_PERCENT = 12;
  localparam int FULL_SCALE = 32768;
  localparam int REPORT_LIMIT = 10;

  // quarter sine polynomial, Q16
  localparam longint unsigned POLY_A = 102944;
  localparam longint unsigned POLY_B = 42047;
  localparam longint unsigned POLY_C = 4640;

  // request kinds
  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               finished;
  } frame_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = KIND_BLOCK;
  logic [6:0]         frame_count = 7'd1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] sample;
  logic               last;
  logic               finished;

  // oscillator mirror: configuration and running state
  logic [1:0]  cfg_wave = WAVE_SINE;
  logic [31:0] cfg_step = '0;
  logic [15:0] cfg_gain = 16'd32768;
  logic [31:0] cfg_length = '0;
  logic [31:0] nco_phase = '0;
  logic [31:0] frame_pos = '0;

  frame_result_t pending_samples[$];
  int mismatch_count = 0;
  bit no_idle = 1'b0;
  int hold_left = 0;

  waveform_oscillator dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .frame_count (frame_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample),
    .last        (last),
    .finished    (finished)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sample channel backpressure, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic void note_mismatch(string what, frame_result_t want,
                                        frame_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%s: expected sample %0d last %0b finished %0b, got sample %0d last %0b finished %0b",
               what, want.sample, want.last, want.finished,
               got.sample, got.last, got.finished);
  endfunction

  // compare each accepted sample with the oldest prediction
  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.sample = sample;
      got.last = last;
      got.finished = finished;
      if (pending_samples.size() == 0) begin
        note_mismatch("unexpected sample", '0, got);
      end else begin
        want = pending_samples.pop_front();
        if (got.sample !== want.sample || got.last !== want.last ||
            got.finished !== want.finished)
          note_mismatch("sample mismatch", want, got);
      end
    end
  end

  // expected samples for one accepted request
  task automatic predict_frames(input logic req_kind, input logic [6:0] req_count);
    int n;
    int v;
    int mag;
    logic [31:0] q;
    logic [9:0] idx;
    longint unsigned x, x2, t, u, y, s;
    longint prod, amp, scaled;
    frame_result_t r;
    if (req_kind == KIND_RESTART) begin
      nco_phase = '0;
      frame_pos = '0;
      return;
    end
    n = (req_count > BLOCK_MAX) ? BLOCK_MAX : req_count;
    for (int i = 0; i < n; i++) begin
      r.sample = '0;
      if (cfg_length == 0 || frame_pos < cfg_length) begin
        case (cfg_wave)
          WAVE_SINE: begin
            // quadrant from the top index bits, mirrored in odd quadrants
            idx = nco_phase[31:22];
            x = {idx[7:0], 8'h00};
            if (idx[8]) x = 65536 - x;
            x2 = (x * x) >> 16;
            t = POLY_B - ((x2 * POLY_C) >> 16);
            u = POLY_A - ((x2 * t) >> 16);
            y = (x * u) >> 16;
            s = (y + 1) >> 1;
            if (s > FULL_SCALE) s = FULL_SCALE;
            v = idx[9] ? -int'(s) : int'(s);
          end
          WAVE_SQUARE: v = nco_phase[31] ? -FULL_SCALE : FULL_SCALE;
          WAVE_SAW: begin
            q = nco_phase + 32'h8000_0000;
            v = {16'h0000, q[31:16]};
            v = v - FULL_SCALE;
          end
          default: begin
            q = nco_phase + 32'hC000_0000;
            mag = {16'h0000, q[31:16]};
            mag = mag - FULL_SCALE;
            if (mag < 0) mag = -mag;
            v = 2 * mag - FULL_SCALE;
          end
        endcase
        // gain with round half up, then saturate
        amp = cfg_gain;
        prod = v;
        prod = prod * amp;
        scaled = (prod + 16384) >>> 15;
        if (scaled > 32767) scaled = 32767;
        if (scaled < -32768) scaled = -32768;
        r.sample = scaled[15:0];
        nco_phase = nco_phase + cfg_step;
        frame_pos = frame_pos + 1;
      end
      r.last = (i + 1 == n);
      r.finished = (cfg_length != 0) && (frame_pos >= cfg_length);
      pending_samples.push_back(r);
    end
  endtask

  // offer one request and hold it until accepted
  task automatic send_request(input logic req_kind, input logic [6:0] req_count);
    int gap;
    gap = 0;
    if (!no_idle)
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= req_kind;
    frame_count <= req_count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frames(req_kind, req_count);
  endtask

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6)
      send_request(KIND_RESTART, 7'($urandom));
    else if (pick < 8)
      send_request(KIND_BLOCK, 7'd0);
    else if (pick < 10)
      send_request(KIND_BLOCK, 7'($urandom_range(65, 127)));
    else if (pick < 22)
      send_request(KIND_BLOCK, 7'($urandom_range(17, 64)));
    else
      send_request(KIND_BLOCK, 7'($urandom_range(1, 16)));
  endtask

  // drain all samples, then let a trailing restart or empty request finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (index)
      REG_WAVEFORM:   cfg_wave = value[1:0];
      REG_PHASE_STEP: cfg_step = value;
      REG_AMPLITUDE:  cfg_gain = value[15:0];
      REG_LENGTH:     cfg_length = value;
      default: ;
    endcase
  endtask

  task automatic randomize_config();
    int pick;
    logic [31:0] len;
    write_reg(REG_WAVEFORM, 32'($urandom_range(3)));
    pick = $urandom_range(99);
    if (pick < 5) write_reg(REG_PHASE_STEP, 32'h0);
    else if (pick < 10) write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    else if (pick < 40) write_reg(REG_PHASE_STEP, 32'($urandom_range(1, 1 << 26)));
    else write_reg(REG_PHASE_STEP, $urandom);
    pick = $urandom_range(99);
    if (pick < 8) write_reg(REG_AMPLITUDE, 32'd0);
    else if (pick < 18) write_reg(REG_AMPLITUDE, 32'd32768);
    else if (pick < 28) write_reg(REG_AMPLITUDE, 32'($urandom_range(32769, 65535)));
    else write_reg(REG_AMPLITUDE, 32'($urandom_range(0, 32768)));
    // length ahead of the current position, at it, huge, or endless
    pick = $urandom_range(99);
    if (pick < 25) len = frame_pos + 32'($urandom_range(1, 60));
    else if (pick < 32) len = frame_pos;
    else if (pick < 37) len = $urandom;
    else len = '0;
    write_reg(REG_LENGTH, len);
  endtask

  // defaults after reset: sine at zero step gives silence
  task automatic test_reset_values();
    send_request(KIND_BLOCK, 7'd4);
    send_request(KIND_BLOCK, 7'd1);
  endtask

  // one full cycle of every waveform from phase zero
  task automatic test_waveforms();
    logic [1:0] shapes[4];
    shapes = '{WAVE_SINE, WAVE_SQUARE, WAVE_SAW, WAVE_TRIANGLE};
    write_reg(REG_PHASE_STEP, 32'h0400_0000);
    foreach (shapes[i]) begin
      write_reg(REG_WAVEFORM, 32'(shapes[i]));
      send_request(KIND_RESTART, 7'd0);
      send_request(KIND_BLOCK, 7'd64);
    end
  endtask

  // empty, oversized and single-frame requests
  task automatic test_block_sizes();
    write_reg(REG_PHASE_STEP, 32'h0123_4567);
    send_request(KIND_BLOCK, 7'd0);
    send_request(KIND_BLOCK, 7'd127);
    send_request(KIND_BLOCK, 7'd65);
    send_request(KIND_BLOCK, 7'd1);
  endtask

  // zero gain, gain above unity, and the largest phase step
  task automatic test_gain_extremes();
    write_reg(REG_AMPLITUDE, 32'd0);
    send_request(KIND_BLOCK, 7'd8);
    write_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
    write_reg(REG_AMPLITUDE, 32'hFFFF);
    send_request(KIND_BLOCK, 7'd4);
    write_reg(REG_WAVEFORM, 32'(WAVE_SAW));
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE, 32'd32768);
    send_request(KIND_BLOCK, 7'd4);
  endtask

  // bounded length: end inside a block, past the end, length lowered below position
  task automatic test_length_limit();
    write_reg(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
    write_reg(REG_PHASE_STEP, 32'h1000_0000);
    write_reg(REG_LENGTH, 32'd5);
    send_request(KIND_RESTART, 7'd0);
    send_request(KIND_BLOCK, 7'd8);
    send_request(KIND_BLOCK, 7'd2);
    write_reg(REG_LENGTH, 32'd3);
    send_request(KIND_BLOCK, 7'd2);
    send_request(KIND_RESTART, 7'd127);
    send_request(KIND_BLOCK, 7'd4);
    write_reg(REG_LENGTH, 32'hFFFF_FFFF);
    send_request(KIND_BLOCK, 7'd1);
    write_reg(REG_LENGTH, 32'd0);
  endtask

  task automatic test_random_phases();
    repeat (10) begin
      randomize_config();
      repeat (20) send_random_request();
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_backlog();
    randomize_config();
    hold_left = 400;
    repeat (12) send_request(KIND_BLOCK, 7'($urandom_range(2, 6)));
  endtask

  // sender stops until every sample has come back
  task automatic test_sender_pause();
    randomize_config();
    repeat (2) begin
      repeat (10) send_random_request();
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_samples.size() != 0);
    end
  endtask

  // back to back traffic with no idling on either side
  task automatic test_steady_stream();
    randomize_config();
    no_idle = 1'b1;
    repeat (20) send_random_request();
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_waveforms();
    test_block_sizes();
    test_gain_extremes();
    test_length_limit();
    test_random_phases();
    test_output_backlog();
    test_sender_pause();
    test_steady_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
sv/wosc_pkg.sv
sv/waveform_oscillator.sv
dv/testbench.sv
